>>> design/csp_pkg.sv
// Package for the command sentence parser: characters, status codes,
// command table and the frame summary passed from front to back.
// No dependencies.
`default_nettype none

package csp_pkg;

    localparam int FRAME_MAX_DEF  = 64;
    localparam int PARAMS_MAX_DEF = 4;
    localparam int NAME_MAX_DEF   = 7;

    localparam int CMD_NUM     = 17;
    localparam int CMD_TXT_MAX = 6;
    localparam int Q_DEPTH     = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FORMAT  = 3'd1,
        ST_CSUM    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_PCOUNT  = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // names right-aligned, zero padded
    localparam logic [CMD_TXT_MAX*8-1:0] CMD_TXT [CMD_NUM] = '{
        "SVR", "SCA", "SSR", "SSP", "SMD", "START", "STOP", "PAUSE", "RESUME",
        "QVR", "QCA", "QSR", "QSP", "QST", "QALL", "RESET", "HELP"
    };
    localparam logic [3:0] CMD_LEN [CMD_NUM] = '{
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd5, 4'd4, 4'd5, 4'd6,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd5, 4'd4
    };
    localparam logic [2:0] CMD_NP [CMD_NUM] = '{
        3'd2, 3'd1, 3'd1, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    // Character at position pos of command k, zero past its end.
    function automatic logic [7:0] cmd_char(input int unsigned k, input logic [3:0] pos);
        logic [CMD_TXT_MAX*8-1:0] sh;
        logic [3:0] off;
        off = CMD_LEN[k] - 4'd1 - pos;
        sh  = CMD_TXT[k] >> {off[2:0], 3'b000};
        return (pos < CMD_LEN[k]) ? sh[7:0] : 8'h00;
    endfunction

    // One finished frame (or a dropped one), classified.
    typedef struct packed {
        logic               ovf;
        logic               name_empty;
        logic [CMD_NUM-1:0] hit;
        logic [2:0]         fcnt;
        logic               star;
        logic               csum_bad;
        logic               csum_mis;
    } t_frame_sum;

endpackage

`default_nettype wire

>>> design/command_sentence_parser.sv
// Command sentence parser top level: byte-stream front end, summary queue,
// judging back end. Depends on csp_pkg, csp_front, csp_queue, csp_back.
//
//   channel | direction | handshake                  | payload
//   rx      | in        | i_rx_valid / o_rx_ready    | i_rx_byte[7:0]
//   result  | out       | o_res_valid / i_res_ready  | o_status, o_command_index,
//           |           |                            | o_param_count, o_had_checksum
//
// One byte per cycle is taken while o_rx_ready is high; all frame tracking
// happens in the byte's own cycle in the front end. A frame end or overflow
// pushes a summary into a two-entry queue; the result is registered in the
// queue, then in the output register. o_rx_ready drops only while the
// queue is full, which takes a stalled result port plus two more finished
// frames. Reset is synchronous, active low, and returns the parser to idle.
`default_nettype none

module command_sentence_parser #(
    parameter int FRAME_MAX  = csp_pkg::FRAME_MAX_DEF,
    parameter int PARAMS_MAX = csp_pkg::PARAMS_MAX_DEF,
    parameter int NAME_MAX   = csp_pkg::NAME_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [2:0]       o_status,
    output logic [4:0]       o_command_index,
    output logic [2:0]       o_param_count,
    output logic             o_had_checksum
);
    import csp_pkg::*;

    logic       rx_accept;
    logic       q_push, q_pop, q_full, q_empty;
    t_frame_sum q_in, q_out;

    // front takes bytes whenever the queue has room for a summary
    assign o_rx_ready = !q_full;
    assign rx_accept  = i_rx_valid && o_rx_ready;

    csp_front #(
        .FRAME_MAX  (FRAME_MAX),
        .PARAMS_MAX (PARAMS_MAX),
        .NAME_MAX   (NAME_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (q_push),
        .o_sum     (q_in)
    );

    csp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back pulls a summary when the output register is free or being drained
    csp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sum_valid     (!q_empty),
        .i_sum           (q_out),
        .o_pop           (q_pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_status        (o_status),
        .o_command_index (o_command_index),
        .o_param_count   (o_param_count),
        .o_had_checksum  (o_had_checksum)
    );

`ifndef NO_ASSERTIONS
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_FULL |->
            o_command_index == 5'd0 && o_param_count == 3'd0 && !o_had_checksum)
        else $error("buffer-full result carries nonzero fields");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status != ST_OK && o_status != ST_PCOUNT |->
            o_command_index == 5'd0)
        else $error("command index set on a failed lookup");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full || q_pop)
        else $error("summary pushed into a full queue");

    a_pc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_param_count <= 3'(PARAMS_MAX))
        else $error("parameter count above cap");
`endif

endmodule

`default_nettype wire

>>> design/csp_front.sv
// Front end: takes one byte per transaction, tracks the frame, and pushes a
// classified frame summary at frame end or overflow. Depends on csp_pkg.
`default_nettype none

module csp_front #(
    parameter int FRAME_MAX  = csp_pkg::FRAME_MAX_DEF,
    parameter int PARAMS_MAX = csp_pkg::PARAMS_MAX_DEF,
    parameter int NAME_MAX   = csp_pkg::NAME_MAX_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_rx_byte,
    output logic                     o_push,
    output csp_pkg::t_frame_sum      o_sum
);
    import csp_pkg::*;

    localparam int FC_W = $clog2(FRAME_MAX);
    localparam int NL_W = $clog2(NAME_MAX + 1);

    typedef struct packed {
        logic [7:0]         xr;
        logic [NL_W-1:0]    nlen;
        logic [2:0]         fcnt;
        logic               in_f;
        logic               star;
        logic [8:0]         hex;
        logic               hbad;
        logic [CMD_NUM-1:0] match;
    } t_parse_st;

    function automatic t_parse_st clear_state();
        t_parse_st s;
        s       = '0;
        s.match = '1;
        return s;
    endfunction

    function automatic t_parse_st feed(input t_parse_st s, input logic [7:0] c);
        t_parse_st   r;
        logic [3:0]  d;
        logic        dv;
        logic [12:0] v;
        logic [3:0]  pos;
        r   = s;
        d   = 4'd0;
        dv  = 1'b1;
        v   = '0;
        pos = 4'(s.nlen);
        if (s.star) begin
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c[3:0];
            end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
                d = c[3:0] + 4'd9;
            end else begin
                dv = 1'b0;
            end
            if (!dv) begin
                r.hbad = 1'b1;
            end else begin
                v     = {s.hex, 4'b0000} + 13'(d);
                r.hex = (v > 13'h100) ? 9'h100 : v[8:0];
            end
        end else if (c == CH_STAR) begin
            r.star = 1'b1;
        end else begin
            r.xr = s.xr ^ c;
            if (c == CH_COMMA) begin
                r.in_f = 1'b0;
            end else begin
                if (!s.in_f) begin
                    r.in_f = 1'b1;
                    if (s.nlen != '0 && s.fcnt < PARAMS_MAX)
                        r.fcnt = s.fcnt + 3'd1;
                end
                // name chars go straight into the per-command match bits
                if (r.fcnt == 3'd0 && s.nlen < NAME_MAX) begin
                    for (int k = 0; k < CMD_NUM; k++)
                        r.match[k] = s.match[k] && (pos < CMD_LEN[k]) &&
                                     (c == cmd_char(k, pos));
                    r.nlen = s.nlen + NL_W'(1);
                end
            end
        end
        return r;
    endfunction

    function automatic t_frame_sum summarize(input t_parse_st s);
        t_frame_sum f;
        f            = '0;
        f.name_empty = (s.nlen == '0);
        for (int k = 0; k < CMD_NUM; k++)
            f.hit[k] = s.match[k] && (CMD_LEN[k] == 4'(s.nlen));
        f.fcnt       = s.fcnt;
        f.star       = s.star;
        f.csum_bad   = s.star && (s.hbad || s.hex > 9'h0FF);
        f.csum_mis   = s.star && (s.hex != {1'b0, s.xr});
        return f;
    endfunction

    t_parse_st       r_st, n_st, mid_st;
    logic [FC_W-1:0] r_fc, n_fc;
    logic            r_pend, n_pend;

    always_comb begin
        n_st   = r_st;
        n_fc   = r_fc;
        n_pend = r_pend;
        mid_st = r_pend ? feed(r_st, CH_CR) : r_st;
        o_push = 1'b0;
        o_sum  = '0;
        if (i_accept) begin
            if (r_fc == '0) begin
                if (i_rx_byte == CH_DOLLAR) begin
                    n_fc    = FC_W'(1);
                    n_st.xr = CH_DOLLAR;
                end
            end else if (r_fc >= FC_W'(FRAME_MAX - 1)) begin
                o_push    = 1'b1;
                o_sum.ovf = 1'b1;
                n_st      = clear_state();
                n_fc      = '0;
                n_pend    = 1'b0;
            end else begin
                n_fc = r_fc + FC_W'(1);
                if (r_pend && i_rx_byte == CH_LF) begin
                    o_push = 1'b1;
                    o_sum  = summarize(r_st);
                    n_st   = clear_state();
                    n_fc   = '0;
                    n_pend = 1'b0;
                end else if (i_rx_byte == CH_CR) begin
                    n_st   = mid_st;
                    n_pend = 1'b1;
                end else begin
                    n_st   = feed(mid_st, i_rx_byte);
                    n_pend = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= clear_state();
            r_fc   <= '0;
            r_pend <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_fc   <= n_fc;
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

>>> design/csp_queue.sv
// Short FIFO of frame summaries between front and back.
// Depends on csp_pkg.
`default_nettype none

module csp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire csp_pkg::t_frame_sum i_data,
    input  wire logic                i_pop,
    output csp_pkg::t_frame_sum      o_data,
    output logic                     o_full,
    output logic                     o_empty
);
    import csp_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_frame_sum      r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/csp_back.sv
// Back end: judges a frame summary (overflow, checksum, name lookup, parameter
// count) and holds the result in the output register. Depends on csp_pkg.
`default_nettype none

module csp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_sum_valid,
    input  wire csp_pkg::t_frame_sum i_sum,
    output logic                     o_pop,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready,
    output logic [2:0]               o_status,
    output logic [4:0]               o_command_index,
    output logic [2:0]               o_param_count,
    output logic                     o_had_checksum
);
    import csp_pkg::*;

    t_status    n_status, r_status;
    logic [4:0] n_idx, r_idx, first_idx;
    logic [2:0] n_pc, r_pc;
    logic       n_hc, r_hc;
    logic       r_valid;

    // lowest table position wins
    always_comb begin
        first_idx = 5'd0;
        for (int k = CMD_NUM - 1; k >= 0; k--)
            if (i_sum.hit[k])
                first_idx = 5'(k);
    end

    always_comb begin
        n_status = ST_OK;
        n_idx    = 5'd0;
        n_pc     = i_sum.fcnt;
        n_hc     = i_sum.star;
        if (i_sum.ovf) begin
            n_status = ST_FULL;
            n_pc     = 3'd0;
            n_hc     = 1'b0;
        end else if (i_sum.csum_bad) begin
            n_status = ST_CSUM;
        end else if (i_sum.name_empty) begin
            n_status = ST_FORMAT;
        end else if (i_sum.csum_mis) begin
            n_status = ST_CSUM;
        end else if (i_sum.hit == '0) begin
            n_status = ST_UNKNOWN;
        end else begin
            n_idx    = first_idx;
            n_status = (i_sum.fcnt == CMD_NP[first_idx]) ? ST_OK : ST_PCOUNT;
        end
    end

    assign o_pop = i_sum_valid && (!r_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_idx    <= n_idx;
            r_pc     <= n_pc;
            r_hc     <= n_hc;
        end
    end

    assign o_res_valid     = r_valid;
    assign o_status        = r_status;
    assign o_command_index = r_idx;
    assign o_param_count   = r_pc;
    assign o_had_checksum  = r_hc;

endmodule

`default_nettype wire
